>>> rtl/ibmw_pkg.sv
package ibmw_pkg;

    // Geometry of the pointer table and of an indirect block
    localparam int WORDS_PER_BLOCK = 512;
    localparam int DIRECT_SLOTS    = 7;
    localparam int SINGLE_SLOT     = DIRECT_SLOTS;
    localparam int DOUBLE_SLOT     = DIRECT_SLOTS + 1;
    localparam int TABLE_DEPTH     = DIRECT_SLOTS + 2;
    localparam int SLOT_BITS       = $clog2(TABLE_DEPTH);
    localparam int WORD_BITS       = $clog2(WORDS_PER_BLOCK);

    // Field widths
    localparam int ZONE_W   = 16;
    localparam int BLOCK_W  = 32;
    localparam int OP_W     = 2;
    localparam int SLOTF_W  = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    // Region limits on the logical block
    localparam logic [BLOCK_W-1:0] LB_DIRECT_END = BLOCK_W'(DIRECT_SLOTS);
    localparam logic [BLOCK_W-1:0] LB_DOUBLE_BASE = BLOCK_W'(DIRECT_SLOTS + WORDS_PER_BLOCK);
    localparam logic [BLOCK_W-1:0] LB_WORDS = BLOCK_W'(WORDS_PER_BLOCK);
    localparam logic [BLOCK_W-1:0] LB_WORDS_SQ = BLOCK_W'(WORDS_PER_BLOCK * WORDS_PER_BLOCK);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MAPPED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HOLE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READFAIL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

    // Result kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_FINAL   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT      = 1'd1;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_DBL1,
        PH_DBL2
    } phase_t;

    typedef enum logic [1:0] {
        RG_DIRECT,
        RG_SINGLE,
        RG_DOUBLE,
        RG_BEYOND
    } region_t;

    typedef enum logic [1:0] {
        WS_SINGLE,
        WS_DOUBLE,
        WS_SECOND
    } word_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic                capture;
        logic                load_slot;
        logic                save_index;
        logic                emit;
        logic                emit_kind;
        logic [STATUS_W-1:0] final_status;
        word_sel_t           word_sel;
        phase_t              phase;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        region_t         region;
        logic            ptr_zero;
        logic            ptr_bad;
        logic            read_ok;
    } stat_t;

endpackage

>>> rtl/ibmw_datapath.sv
module ibmw_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ibmw_pkg::cmd_t                      cmd,
    output ibmw_pkg::stat_t                     stat,
    input  logic                                reg_write,
    input  logic [ibmw_pkg::CFG_IDX_W-1:0]      reg_index,
    input  logic [ibmw_pkg::ZONE_W-1:0]         reg_data,
    input  logic [ibmw_pkg::OP_W-1:0]           operation,
    input  logic [ibmw_pkg::SLOTF_W-1:0]        slot,
    input  logic [ibmw_pkg::ZONE_W-1:0]         slot_zone,
    input  logic [ibmw_pkg::BLOCK_W-1:0]        logical_block,
    input  logic [ibmw_pkg::ZONE_W-1:0]         read_word,
    input  logic                                read_ok,
    output logic                                done,
    output logic                                kind,
    output logic [ibmw_pkg::ZONE_W-1:0]         request_zone,
    output logic [ibmw_pkg::WORD_BITS-1:0]      request_word,
    output logic [ibmw_pkg::ZONE_W-1:0]         mapped_zone,
    output logic [ibmw_pkg::STATUS_W-1:0]       status
);

    logic [ibmw_pkg::ZONE_W-1:0]    first_data_zone_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    zone_count_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    pointer_table [ibmw_pkg::TABLE_DEPTH];
    logic [ibmw_pkg::WORD_BITS-1:0] second_index_reg;

    logic [ibmw_pkg::OP_W-1:0]      op_reg;
    logic [ibmw_pkg::SLOTF_W-1:0]   slot_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    slot_zone_reg;
    logic [ibmw_pkg::BLOCK_W-1:0]   lblock_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    read_word_reg;
    logic                           read_ok_reg;

    logic                           done_reg;
    logic                           kind_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    request_zone_reg;
    logic [ibmw_pkg::WORD_BITS-1:0] request_word_reg;
    logic [ibmw_pkg::ZONE_W-1:0]    mapped_zone_reg;
    logic [ibmw_pkg::STATUS_W-1:0]  status_reg;

    logic [ibmw_pkg::BLOCK_W-1:0]   b_single;
    logic [ibmw_pkg::BLOCK_W-1:0]   b_double;
    ibmw_pkg::region_t              region;
    logic [ibmw_pkg::SLOT_BITS-1:0] table_idx;
    logic [ibmw_pkg::ZONE_W-1:0]    ptr;
    logic [ibmw_pkg::WORD_BITS-1:0] word_pick;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_data_zone_reg <= '0;
            zone_count_reg      <= '0;
        end
        else if (reg_write)
        begin
            case (reg_index)
                ibmw_pkg::CFG_FIRST_DATA_ZONE: first_data_zone_reg <= reg_data;
                ibmw_pkg::CFG_ZONE_COUNT:      zone_count_reg      <= reg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= operation;
            slot_reg      <= slot;
            slot_zone_reg <= slot_zone;
            lblock_reg    <= logical_block;
            read_word_reg <= read_word;
            read_ok_reg   <= read_ok;
        end
    end

    // Load a pointer slot; loads beyond the table are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.load_slot && (slot_reg < ibmw_pkg::SLOTF_W'(ibmw_pkg::TABLE_DEPTH)))
        begin
            pointer_table[slot_reg[ibmw_pkg::SLOT_BITS-1:0]] <= slot_zone_reg;
        end
    end

    // Classify the logical block
    assign b_single = lblock_reg - ibmw_pkg::LB_DIRECT_END;
    assign b_double = lblock_reg - ibmw_pkg::LB_DOUBLE_BASE;

    always_comb
    begin
        if (lblock_reg < ibmw_pkg::LB_DIRECT_END)
            region = ibmw_pkg::RG_DIRECT;
        else if (b_single < ibmw_pkg::LB_WORDS)
            region = ibmw_pkg::RG_SINGLE;
        else if (b_double < ibmw_pkg::LB_WORDS_SQ)
            region = ibmw_pkg::RG_DOUBLE;
        else
            region = ibmw_pkg::RG_BEYOND;
    end

    // Pick the table slot and the pointer under test
    always_comb
    begin
        case (region)
            ibmw_pkg::RG_DIRECT: table_idx = lblock_reg[ibmw_pkg::SLOT_BITS-1:0];
            ibmw_pkg::RG_SINGLE: table_idx = ibmw_pkg::SLOT_BITS'(ibmw_pkg::SINGLE_SLOT);
            default:             table_idx = ibmw_pkg::SLOT_BITS'(ibmw_pkg::DOUBLE_SLOT);
        endcase
        if (cmd.phase == ibmw_pkg::PH_IDLE)
            ptr = pointer_table[table_idx];
        else
            ptr = read_word_reg;
    end

    // Report to the controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.region   = region;
        stat.ptr_zero = (ptr == '0);
        stat.ptr_bad  = (ptr < first_data_zone_reg) || (ptr >= zone_count_reg);
        stat.read_ok  = read_ok_reg;
    end

    // Word index for a read request
    always_comb
    begin
        case (cmd.word_sel)
            ibmw_pkg::WS_SINGLE: word_pick = b_single[ibmw_pkg::WORD_BITS-1:0];
            ibmw_pkg::WS_DOUBLE:
                word_pick = b_double[2*ibmw_pkg::WORD_BITS-1:ibmw_pkg::WORD_BITS];
            default:             word_pick = second_index_reg;
        endcase
    end

    // Keep the second-level index for the last read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_index_reg <= '0;
        else if (cmd.save_index)
            second_index_reg <= b_double[ibmw_pkg::WORD_BITS-1:0];
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg <= cmd.emit_kind;
            if (cmd.emit_kind == ibmw_pkg::KIND_REQUEST)
            begin
                request_zone_reg <= ptr;
                request_word_reg <= word_pick;
                mapped_zone_reg  <= '0;
                status_reg       <= ibmw_pkg::ST_MAPPED;
            end
            else
            begin
                request_zone_reg <= '0;
                request_word_reg <= '0;
                mapped_zone_reg  <= (cmd.final_status == ibmw_pkg::ST_MAPPED) ? ptr : '0;
                status_reg       <= cmd.final_status;
            end
        end
    end

    assign done         = done_reg;
    assign kind         = kind_reg;
    assign request_zone = request_zone_reg;
    assign request_word = request_word_reg;
    assign mapped_zone  = mapped_zone_reg;
    assign status       = status_reg;

endmodule

>>> rtl/ibmw_ctrl.sv
module ibmw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ibmw_pkg::stat_t stat,
    output ibmw_pkg::cmd_t  cmd
);

    ibmw_pkg::ctrl_state_t state_reg;
    ibmw_pkg::ctrl_state_t state_next;
    ibmw_pkg::phase_t      phase_reg;
    ibmw_pkg::phase_t      phase_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ibmw_pkg::CS_IDLE;
            phase_reg <= ibmw_pkg::PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cmd.capture      = 1'b0;
        cmd.load_slot    = 1'b0;
        cmd.save_index   = 1'b0;
        cmd.emit         = 1'b0;
        cmd.emit_kind    = ibmw_pkg::KIND_FINAL;
        cmd.final_status = ibmw_pkg::ST_MAPPED;
        cmd.word_sel     = ibmw_pkg::WS_SECOND;
        cmd.phase        = phase_reg;
        busy             = (state_reg == ibmw_pkg::CS_EXEC);

        case (state_reg)
            ibmw_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ibmw_pkg::CS_EXEC;
                end
            end

            ibmw_pkg::CS_EXEC:
            begin
                state_next = ibmw_pkg::CS_IDLE;
                case (stat.op)
                    ibmw_pkg::OP_LOAD:
                    begin
                        cmd.load_slot = 1'b1;
                    end

                    // Start a walk; ignored while one is pending
                    ibmw_pkg::OP_MAP:
                    begin
                        if (phase_reg == ibmw_pkg::PH_IDLE)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.region == ibmw_pkg::RG_BEYOND)
                                cmd.final_status = ibmw_pkg::ST_RANGE;
                            else if (stat.ptr_zero)
                                cmd.final_status = ibmw_pkg::ST_HOLE;
                            else if (stat.ptr_bad)
                                cmd.final_status = ibmw_pkg::ST_BOUNDS;
                            else if (stat.region == ibmw_pkg::RG_SINGLE)
                            begin
                                cmd.emit_kind = ibmw_pkg::KIND_REQUEST;
                                cmd.word_sel  = ibmw_pkg::WS_SINGLE;
                                phase_next    = ibmw_pkg::PH_SINGLE;
                            end
                            else if (stat.region == ibmw_pkg::RG_DOUBLE)
                            begin
                                cmd.emit_kind  = ibmw_pkg::KIND_REQUEST;
                                cmd.word_sel   = ibmw_pkg::WS_DOUBLE;
                                cmd.save_index = 1'b1;
                                phase_next     = ibmw_pkg::PH_DBL1;
                            end
                        end
                    end

                    // Take a read response; stray responses are dropped
                    ibmw_pkg::OP_RESP:
                    begin
                        if (phase_reg != ibmw_pkg::PH_IDLE)
                        begin
                            cmd.emit   = 1'b1;
                            phase_next = ibmw_pkg::PH_IDLE;
                            if (!stat.read_ok)
                                cmd.final_status = ibmw_pkg::ST_READFAIL;
                            else if (stat.ptr_zero)
                                cmd.final_status = ibmw_pkg::ST_HOLE;
                            else if (stat.ptr_bad)
                                cmd.final_status = ibmw_pkg::ST_BOUNDS;
                            else if (phase_reg == ibmw_pkg::PH_DBL1)
                            begin
                                cmd.emit_kind = ibmw_pkg::KIND_REQUEST;
                                cmd.word_sel  = ibmw_pkg::WS_SECOND;
                                phase_next    = ibmw_pkg::PH_DBL2;
                            end
                        end
                    end

                    default: ;
                endcase
            end

            default:
            begin
                state_next = ibmw_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/inode_block_map_walker.sv
// A request is captured when start is taken while idle, then executed in the execute state
// of the controller; its result, if any, is registered onto the outputs with done high.
// No new request is taken while busy is high during execution; start is taken again
// while the previous result is shown.
// Reset (rst_n low, asynchronous): controller idle, no walk pending, config zero;
// the pointer table holds nothing until loaded. The receiver cannot stall results.
module inode_block_map_walker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                reg_write,
    input  logic [ibmw_pkg::CFG_IDX_W-1:0]      reg_index,
    input  logic [ibmw_pkg::ZONE_W-1:0]         reg_data,
    input  logic [ibmw_pkg::OP_W-1:0]           operation,
    input  logic [ibmw_pkg::SLOTF_W-1:0]        slot,
    input  logic [ibmw_pkg::ZONE_W-1:0]         slot_zone,
    input  logic [ibmw_pkg::BLOCK_W-1:0]        logical_block,
    input  logic [ibmw_pkg::ZONE_W-1:0]         read_word,
    input  logic                                read_ok,
    output logic                                done,
    output logic                                kind,
    output logic [ibmw_pkg::ZONE_W-1:0]         request_zone,
    output logic [ibmw_pkg::WORD_BITS-1:0]      request_word,
    output logic [ibmw_pkg::ZONE_W-1:0]         mapped_zone,
    output logic [ibmw_pkg::STATUS_W-1:0]       status
);

    ibmw_pkg::cmd_t  cmd;
    ibmw_pkg::stat_t stat;

    ibmw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ibmw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .reg_write     (reg_write),
        .reg_index     (reg_index),
        .reg_data      (reg_data),
        .operation     (operation),
        .slot          (slot),
        .slot_zone     (slot_zone),
        .logical_block (logical_block),
        .read_word     (read_word),
        .read_ok       (read_ok),
        .done          (done),
        .kind          (kind),
        .request_zone  (request_zone),
        .request_word  (request_word),
        .mapped_zone   (mapped_zone),
        .status        (status)
    );

endmodule
